// ===== hw/rtl/turtle_graphics_interpreter_defines.svh =====
// ----------------------------------------------------------------------------
// Turtle graphics interpreter assertion macros
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TURTLE_GRAPHICS_INTERPRETER_DEFINES_SVH
`define TURTLE_GRAPHICS_INTERPRETER_DEFINES_SVH
`ifndef SYNTHESIS
`define TGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TGI_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define TGI_ASSERT(lbl, prop, msg)
`define TGI_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hw/rtl/tgi_pkg.sv =====
// ----------------------------------------------------------------------------
// Turtle graphics interpreter package
// Sizes, command and error codes, CORDIC angle table and shared types.
// ----------------------------------------------------------------------------
package tgi_pkg;

  localparam int unsigned StackDepth  = 64;
  localparam int unsigned CoordBits   = 24;
  localparam int unsigned AngleBits   = 16;
  localparam int unsigned CordicSteps = 16;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned AmountW  = 16;
  localparam int unsigned HeadOutW = 16;
  localparam int unsigned ErrW     = 2;

  localparam int unsigned VecW     = 32;
  localparam int unsigned TrigFrac = 30;
  localparam int unsigned TabIdxW  = 5;
  localparam int unsigned StepCntW = (CordicSteps > 1) ? $clog2(CordicSteps) : 1;

  localparam int unsigned StackAddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned StackCntW  = $clog2(StackDepth + 1);
  localparam int unsigned EntryW     = 2 * CoordBits + AngleBits;

  localparam int unsigned OutFieldsW = 4 * CoordBits + HeadOutW + ErrW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;
  localparam int unsigned OutPadW    = OutDataW - OutFieldsW;

  localparam logic signed [VecW-1:0] CordicGain = 32'sd652032874;

  typedef enum logic [CmdW-1:0] {
    CMD_FORWARD  = 3'd0,
    CMD_LEFT     = 3'd1,
    CMD_RIGHT    = 3'd2,
    CMD_PUSH     = 3'd3,
    CMD_POP      = 3'd4,
    CMD_RESET    = 3'd5,
    CMD_PEN_DOWN = 3'd6,
    CMD_PEN_UP   = 3'd7
  } cmd_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_SAT   = 2'd3
  } err_e;

  typedef struct packed {
    logic                   done;
    logic                   flip;
    logic signed [VecW-1:0] cos_raw;
    logic signed [VecW-1:0] sin_raw;
  } trig_t;

  function automatic logic [VecW-1:0] atan_lut(input logic [TabIdxW-1:0] idx);
    logic [VecW-1:0] val;
    unique case (idx)
      5'd0:    val = 32'd536870912;
      5'd1:    val = 32'd316933406;
      5'd2:    val = 32'd167458907;
      5'd3:    val = 32'd85004756;
      5'd4:    val = 32'd42667331;
      5'd5:    val = 32'd21354465;
      5'd6:    val = 32'd10680862;
      5'd7:    val = 32'd5340245;
      5'd8:    val = 32'd2670163;
      5'd9:    val = 32'd1335087;
      5'd10:   val = 32'd667544;
      5'd11:   val = 32'd333772;
      5'd12:   val = 32'd166886;
      5'd13:   val = 32'd83443;
      5'd14:   val = 32'd41722;
      5'd15:   val = 32'd20861;
      5'd16:   val = 32'd10430;
      5'd17:   val = 32'd5215;
      5'd18:   val = 32'd2608;
      5'd19:   val = 32'd1304;
      5'd20:   val = 32'd652;
      5'd21:   val = 32'd326;
      5'd22:   val = 32'd163;
      5'd23:   val = 32'd81;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== hw/rtl/tgi_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tgi_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tgi_cordic.sv =====
// ----------------------------------------------------------------------------
// Iterative CORDIC rotator
// One shift-add rotation step per cycle; gives raw cosine and sine of the
// heading with a half-turn fold flag.
// ----------------------------------------------------------------------------
module tgi_cordic import tgi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [AngleBits-1:0] heading_i,
  output trig_t                trig_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [StepCntW-1:0]    cnt_q, cnt_d;
  logic                   flip_q;
  logic signed [VecW-1:0] x_q, y_q, z_q;

  logic [VecW-1:0]        angle;
  logic                   fold;
  logic signed [VecW-1:0] x_sh, y_sh, atan_s;
  logic signed [VecW-1:0] x_nxt, y_nxt, z_nxt;
  logic                   last;

  assign angle  = {heading_i, {(VecW - AngleBits){1'b0}}};
  assign fold   = angle[VecW-1] ^ angle[VecW-2];
  assign x_sh   = x_q >>> cnt_q;
  assign y_sh   = y_q >>> cnt_q;
  assign atan_s = $signed(atan_lut(TabIdxW'(cnt_q)));
  assign last   = (cnt_q == StepCntW'(CordicSteps - 1));

  always_comb begin
    if (!z_q[VecW-1]) begin
      x_nxt = x_q - y_sh;
      y_nxt = y_q + x_sh;
      z_nxt = z_q - atan_s;
    end else begin
      x_nxt = x_q + y_sh;
      y_nxt = y_q - x_sh;
      z_nxt = z_q + atan_s;
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + StepCntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= $signed({angle[VecW-1] ^ fold, angle[VecW-2:0]});
      flip_q <= fold;
    end else if (busy_q) begin
      x_q <= x_nxt;
      y_q <= y_nxt;
      z_q <= z_nxt;
    end
  end

  assign trig_o = '{done: done_q, flip: flip_q, cos_raw: x_q, sin_raw: y_q};

endmodule

// ===== hw/rtl/turtle_graphics_interpreter.sv =====
// Path from request accept to result valid: forward runs 16 CORDIC steps on
// the rotator, then multiply x, multiply y, accumulate y; pop waits for the
// stack RAM read; all other commands go straight to the result load.
// A new request is taken the cycle after the result is loaded, so no request
// is taken while the previous one is still in progress or its result stalls.
// Reset is asynchronous, active low; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
// Turtle graphics interpreter
// Sequencer around a CORDIC rotator, one multiplier and one
// round-add-saturate unit, with a RAM-backed position stack.
// ----------------------------------------------------------------------------
`include "turtle_graphics_interpreter_defines.svh"

module turtle_graphics_interpreter import tgi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [AmountW-1:0]  s_axis_tdata_i,   // amount
  input  logic [CmdW-1:0]     s_axis_tuser_i,   // cmd
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // start_x, start_y, end_x, end_y,
                                                // heading_now, error_code, zero pad
  output logic                m_axis_tuser_o    // line_valid
);

  localparam int unsigned ProdW  = AmountW + 1 + VecW;
  localparam int unsigned DeltaW = ProdW - TrigFrac;
  localparam int unsigned AccW   = ((CoordBits > DeltaW) ? CoordBits : DeltaW) + 1;
  localparam logic signed [ProdW-1:0] RoundBias = ProdW'(1 << (TrigFrac - 1));
  localparam logic [AngleBits-1:0] HeadingInit = AngleBits'(1 << (AngleBits - 2));
  localparam logic [CoordBits-1:0] CoordHi = {1'b0, {(CoordBits - 1){1'b1}}};
  localparam logic [CoordBits-1:0] CoordLo = {1'b1, {(CoordBits - 1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ROTATE  = 7'b0000010,
    S_MULX    = 7'b0000100,
    S_MULY    = 7'b0001000,
    S_ACCY    = 7'b0010000,
    S_POPWAIT = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [CoordBits-1:0]   pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [AngleBits-1:0]   heading_q, heading_d;
  logic                   pen_q, pen_d;
  logic [StackCntW-1:0]   stack_cnt_q, stack_cnt_d;
  logic                   m_valid_q, m_valid_d;

  logic [AmountW-1:0]     amt_q, amt_d;
  logic [CoordBits-1:0]   sx_q, sx_d, sy_q, sy_d;
  err_e                   err_q, err_d;
  logic                   line_q, line_d;
  logic                   sat_q, sat_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [OutDataW-1:0]    out_data_q, out_data_d;
  logic                   out_user_q, out_user_d;

  logic                   in_fire;
  cmd_e                   cmd_in;
  logic [AmountW+AngleBits-1:0]  amt_wide;
  logic [AngleBits-1:0]   turn;
  logic [AngleBits+HeadOutW-1:0] head_wide;
  logic [HeadOutW-1:0]    heading_now;

  logic                   cordic_start;
  trig_t                  trig;

  logic                   ram_we, ram_re;
  logic [StackAddrW-1:0]  ram_waddr, ram_raddr;
  logic [StackCntW-1:0]   cnt_dec;
  logic [EntryW-1:0]      ram_wdata, ram_rdata;

  logic signed [AmountW:0]   mul_a;
  logic signed [VecW-1:0]    trig_sel, mul_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [ProdW-1:0]   rnd_sum;
  logic signed [DeltaW-1:0]  delta;
  logic signed [CoordBits-1:0] acc_base;
  logic signed [AccW-1:0]    acc;
  logic [AccW-CoordBits:0]   acc_top;
  logic                      ovf;
  logic [CoordBits-1:0]      clamped;

  tgi_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cordic_start),
    .heading_i (heading_q),
    .trig_o    (trig)
  );

  tgi_ram #(
    .Width (EntryW),
    .Depth (StackDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_in          = cmd_e'(s_axis_tuser_i);

  assign amt_wide    = {s_axis_tdata_i, {AngleBits{1'b0}}};
  assign turn        = amt_wide[AmountW+AngleBits-1:AmountW];
  assign head_wide   = {heading_q, {HeadOutW{1'b0}}};
  assign heading_now = head_wide[AngleBits+HeadOutW-1:AngleBits];

  assign cnt_dec   = stack_cnt_q - StackCntW'(1);
  assign ram_waddr = stack_cnt_q[StackAddrW-1:0];
  assign ram_raddr = cnt_dec[StackAddrW-1:0];
  assign ram_wdata = {heading_q, pos_y_q, pos_x_q};

  // shared multiplier
  assign mul_a    = $signed({1'b0, amt_q});
  assign trig_sel = (state_q == S_MULX) ? $signed(trig.cos_raw) : $signed(trig.sin_raw);
  assign mul_b    = trig.flip ? -trig_sel : trig_sel;
  assign prod     = mul_a * mul_b;

  // shared round, add and saturate
  assign rnd_sum  = prod_q + RoundBias;
  assign delta    = rnd_sum[ProdW-1:TrigFrac];
  assign acc_base = (state_q == S_MULY) ? $signed(pos_x_q) : $signed(pos_y_q);
  assign acc      = AccW'(acc_base) + AccW'(delta);
  assign acc_top  = acc[AccW-1:CoordBits-1];
  assign ovf      = !((&acc_top) || (~|acc_top));
  assign clamped  = !ovf ? acc[CoordBits-1:0] : (acc[AccW-1] ? CoordLo : CoordHi);

  always_comb begin
    state_d      = state_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    heading_d    = heading_q;
    pen_d        = pen_q;
    stack_cnt_d  = stack_cnt_q;
    m_valid_d    = m_valid_q;
    amt_d        = amt_q;
    sx_d         = sx_q;
    sy_d         = sy_q;
    err_d        = err_q;
    line_d       = line_q;
    sat_d        = sat_q;
    prod_d       = prod_q;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    cordic_start = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          amt_d   = s_axis_tdata_i;
          sx_d    = pos_x_q;
          sy_d    = pos_y_q;
          err_d   = ERR_NONE;
          line_d  = 1'b0;
          sat_d   = 1'b0;
          state_d = S_DONE;
          unique case (cmd_in)
            CMD_FORWARD: begin
              cordic_start = 1'b1;
              state_d      = S_ROTATE;
            end
            CMD_LEFT:  heading_d = heading_q + turn;
            CMD_RIGHT: heading_d = heading_q - turn;
            CMD_PUSH: begin
              if (stack_cnt_q == StackCntW'(StackDepth)) begin
                err_d = ERR_FULL;
              end else begin
                ram_we      = 1'b1;
                stack_cnt_d = stack_cnt_q + StackCntW'(1);
              end
            end
            CMD_POP: begin
              if (stack_cnt_q == '0) begin
                err_d = ERR_EMPTY;
              end else begin
                ram_re      = 1'b1;
                stack_cnt_d = cnt_dec;
                state_d     = S_POPWAIT;
              end
            end
            CMD_RESET: begin
              pos_x_d   = '0;
              pos_y_d   = '0;
              heading_d = HeadingInit;
            end
            CMD_PEN_DOWN: pen_d = 1'b1;
            CMD_PEN_UP:   pen_d = 1'b0;
          endcase
        end
      end
      S_ROTATE: begin
        if (trig.done) begin
          state_d = S_MULX;
        end
      end
      S_MULX: begin
        prod_d  = prod;
        state_d = S_MULY;
      end
      S_MULY: begin
        prod_d  = prod;
        pos_x_d = clamped;
        sat_d   = ovf;
        state_d = S_ACCY;
      end
      S_ACCY: begin
        pos_y_d = clamped;
        if (sat_q || ovf) begin
          err_d = ERR_SAT;
        end
        line_d  = pen_q;
        state_d = S_DONE;
      end
      S_POPWAIT: begin
        pos_x_d   = ram_rdata[CoordBits-1:0];
        pos_y_d   = ram_rdata[2*CoordBits-1:CoordBits];
        heading_d = ram_rdata[EntryW-1:2*CoordBits];
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_data_d = {{OutPadW{1'b0}}, err_q, heading_now, pos_y_q, pos_x_q, sy_q, sx_q};
          out_user_d = line_q;
          m_valid_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= HeadingInit;
      pen_q       <= 1'b0;
      stack_cnt_q <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      heading_q   <= heading_d;
      pen_q       <= pen_d;
      stack_cnt_q <= stack_cnt_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amt_d_hold: begin
      amt_q      <= amt_d;
      sx_q       <= sx_d;
      sy_q       <= sy_d;
      err_q      <= err_d;
      line_q     <= line_d;
      sat_q      <= sat_d;
      prod_q     <= prod_d;
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `TGI_ASSERT(a_stack_bound, stack_cnt_q <= StackCntW'(StackDepth), "stack count past depth")
  `TGI_ASSERT(a_trig_in_rotate, trig.done |-> (state_q == S_ROTATE), "rotator done off sequence")
  `TGI_ASSERT(a_busy_after_req, in_fire |=> !s_axis_tready_o, "ready right after a request")
  `TGI_NEVER(a_pop_underflow, ram_re && (stack_cnt_q == '0), "stack read while empty")

endmodule

// ===== sim/tb_turtle_graphics_interpreter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Turtle graphics interpreter testbench
// Streams turtle commands into the block with random gaps and result-side
// stalls. An in-bench turtle predicts each report (CORDIC direction, rounded
// and clamped moves, bounded stack) and every result is compared against it.
// ----------------------------------------------------------------------------
module tb_turtle_graphics_interpreter;
  import tgi_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam longint      HeadingGain   = 652032874;
  localparam longint      AtanStep [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic                   line_valid;
    logic [CoordBits-1:0]   start_x;
    logic [CoordBits-1:0]   start_y;
    logic [CoordBits-1:0]   end_x;
    logic [CoordBits-1:0]   end_y;
    logic [HeadOutW-1:0]    heading;
    err_e                   err;
  } turtle_report_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [AmountW-1:0] amount;
  } turtle_cmd_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [AmountW-1:0]  s_axis_tdata = '0;    // amount
  logic [CmdW-1:0]     s_axis_tuser = '0;    // cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // start_x, start_y, end_x, end_y,
                                             // heading_now, error_code, zero pad
  logic                m_axis_tuser;         // line_valid

  turtle_cmd_t    command_q [$];
  turtle_report_t reports_q [$];
  int             offered_reqs = 0;
  int             accepted_reqs = 0;
  int             mismatches = 0;
  int             idle_cycles = 0;
  int             src_hold = 0;
  int             sink_hold = 0;
  bit             calm = 1'b0;

  longint                 pos_x, pos_y;
  logic [AngleBits-1:0]   heading;
  bit                     pen_down;
  longint                 saved_x [StackDepth];
  longint                 saved_y [StackDepth];
  logic [AngleBits-1:0]   saved_h [StackDepth];
  int                     stack_used;

  turtle_graphics_interpreter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 70) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [AmountW-1:0] pick_amount();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return '0;
    if (roll < 4) return '1;
    return AmountW'($urandom);
  endfunction

  // Rotation-mode CORDIC from (gain, 0), folded into the right half plane.
  function automatic void heading_to_dir(input logic [AngleBits-1:0] hdg,
                                         output longint cos_q, output longint sin_q);
    logic [31:0] ang;
    bit          flip;
    longint      x, y, z, t;
    ang  = 32'(hdg) << (32 - AngleBits);
    flip = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
    if (flip) ang = ang - 32'h8000_0000;
    z = longint'(signed'(ang));
    x = HeadingGain;
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - AtanStep[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + AtanStep[i];
      end
      x = t;
    end
    cos_q = flip ? -x : x;
    sin_q = flip ? -y : y;
  endfunction

  function automatic longint limit_coord(input longint v, inout bit hit);
    longint hi, lo;
    hi = (longint'(1) <<< (CoordBits - 1)) - 1;
    lo = -(longint'(1) <<< (CoordBits - 1));
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic turtle_report_t advance_turtle(input cmd_e cmd,
                                                    input logic [AmountW-1:0] amount);
    turtle_report_t rep;
    longint         cos_q, sin_q, span, half;
    bit             clipped;
    rep         = '0;
    rep.err     = ERR_NONE;
    rep.start_x = pos_x[CoordBits-1:0];
    rep.start_y = pos_y[CoordBits-1:0];
    clipped     = 1'b0;
    span        = amount;
    half        = longint'(1) <<< (TrigFrac - 1);
    case (cmd)
      CMD_FORWARD: begin
        heading_to_dir(heading, cos_q, sin_q);
        pos_x = limit_coord(pos_x + ((span * cos_q + half) >>> TrigFrac), clipped);
        pos_y = limit_coord(pos_y + ((span * sin_q + half) >>> TrigFrac), clipped);
        if (clipped) rep.err = ERR_SAT;
        rep.line_valid = pen_down;
      end
      CMD_LEFT:  heading = heading + amount;
      CMD_RIGHT: heading = heading - amount;
      CMD_PUSH: begin
        if (stack_used >= StackDepth) begin
          rep.err = ERR_FULL;
        end else begin
          saved_x[stack_used] = pos_x;
          saved_y[stack_used] = pos_y;
          saved_h[stack_used] = heading;
          stack_used++;
        end
      end
      CMD_POP: begin
        if (stack_used == 0) begin
          rep.err = ERR_EMPTY;
        end else begin
          stack_used--;
          pos_x   = saved_x[stack_used];
          pos_y   = saved_y[stack_used];
          heading = saved_h[stack_used];
        end
      end
      CMD_RESET: begin
        pos_x   = 0;
        pos_y   = 0;
        heading = AngleBits'(1) << (AngleBits - 2);
      end
      CMD_PEN_DOWN: pen_down = 1'b1;
      default:      pen_down = 1'b0;
    endcase
    rep.end_x   = pos_x[CoordBits-1:0];
    rep.end_y   = pos_y[CoordBits-1:0];
    rep.heading = heading;
    return rep;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, got %0h", $time, field, want, seen);
    end
  endtask

  // Request side: take at posedge, predict the report.
  // Result side: compare against the oldest prediction.
  always @(posedge clk_i) begin
    turtle_report_t want, seen;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      reports_q.push_back(advance_turtle(cmd_e'(s_axis_tuser), s_axis_tdata));
      accepted_reqs++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (reports_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no request pending, expected none, got %0h",
                 $time, m_axis_tdata);
      end else begin
        want            = reports_q.pop_front();
        seen.line_valid = m_axis_tuser;
        seen.start_x    = m_axis_tdata[0*CoordBits +: CoordBits];
        seen.start_y    = m_axis_tdata[1*CoordBits +: CoordBits];
        seen.end_x      = m_axis_tdata[2*CoordBits +: CoordBits];
        seen.end_y      = m_axis_tdata[3*CoordBits +: CoordBits];
        seen.heading    = m_axis_tdata[4*CoordBits +: HeadOutW];
        seen.err        = err_e'(m_axis_tdata[4*CoordBits+HeadOutW +: ErrW]);
        flag_field("line_valid", 32'(want.line_valid), 32'(seen.line_valid));
        flag_field("start_x", 32'(want.start_x), 32'(seen.start_x));
        flag_field("start_y", 32'(want.start_y), 32'(seen.start_y));
        flag_field("end_x", 32'(want.end_x), 32'(seen.end_x));
        flag_field("end_y", 32'(want.end_y), 32'(seen.end_y));
        flag_field("heading_now", 32'(want.heading), 32'(seen.heading));
        flag_field("error_code", 32'(want.err), 32'(seen.err));
      end
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    turtle_cmd_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && accepted_reqs != offered_reqs) begin
      // hold until taken
    end else if (src_hold > 0) begin
      src_hold--;
      s_axis_tvalid <= 1'b0;
    end else if (command_q.size() != 0) begin
      item = command_q.pop_front();
      s_axis_tuser  <= item.cmd;
      s_axis_tdata  <= item.amount;
      s_axis_tvalid <= 1'b1;
      offered_reqs++;
      src_hold = pick_gap();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold = pick_gap();
    end
  end

  task automatic send(input cmd_e cmd, input logic [AmountW-1:0] amount);
    turtle_cmd_t item;
    item.cmd    = cmd;
    item.amount = amount;
    command_q.push_back(item);
  endtask

  task automatic wait_drained();
    while (command_q.size() != 0 || accepted_reqs != offered_reqs || reports_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    logic [AmountW-1:0] sweep [5];
    int                 sent;
    int                 depth;
    pos_x      = 0;
    pos_y      = 0;
    heading    = AngleBits'(1) << (AngleBits - 2);
    pen_down   = 1'b0;
    stack_used = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, every command, flip boundaries, empty pop
    send(CMD_FORWARD, 16'h0100);
    send(CMD_PEN_DOWN, 16'h0000);
    send(CMD_FORWARD, 16'hFFFF);
    send(CMD_FORWARD, 16'h0000);
    send(CMD_POP, 16'hFFFF);
    send(CMD_PUSH, 16'h0000);
    send(CMD_LEFT, 16'hFFFF);
    send(CMD_FORWARD, 16'h1234);
    send(CMD_RIGHT, 16'h0001);
    send(CMD_RIGHT, 16'hFFFF);
    send(CMD_LEFT, 16'h0000);
    send(CMD_POP, 16'h5A5A);
    send(CMD_RESET, 16'hA5A5);
    send(CMD_LEFT, 16'h4000);
    send(CMD_FORWARD, 16'h8000);
    send(CMD_LEFT, 16'h4000);
    send(CMD_FORWARD, 16'h7FFF);
    send(CMD_RIGHT, 16'h8000);
    send(CMD_FORWARD, 16'hFFFF);
    send(CMD_PEN_UP, 16'hFFFF);
    send(CMD_FORWARD, 16'hAAAA);
    send(CMD_PEN_DOWN, 16'h5555);
    send(CMD_LEFT, 16'h5555);
    send(CMD_FORWARD, 16'h5555);
    send(CMD_RESET, 16'h0000);
    wait_drained();

    // Saturation: long straight runs along each axis and one random heading
    sweep = '{16'hC000, 16'h4000, 16'h0000, 16'h8000, 16'(($urandom))};
    foreach (sweep[k]) begin
      send(CMD_RESET, pick_amount());
      send(CMD_PEN_DOWN, pick_amount());
      send(k[0] ? CMD_RIGHT : CMD_LEFT, k[0] ? 16'(-sweep[k]) : sweep[k]);
      repeat (140) send(CMD_FORWARD, 16'hF000 | 16'($urandom));
    end
    send(CMD_RESET, pick_amount());

    // Stack: fill past full, then unwind past empty
    for (int i = 0; i < StackDepth + 2; i++) begin
      send(CMD_FORWARD, pick_amount());
      send(CMD_LEFT, pick_amount());
      send(CMD_PUSH, pick_amount());
    end
    for (int i = 0; i < StackDepth + 2; i++) begin
      send(CMD_POP, pick_amount());
      send(CMD_FORWARD, pick_amount());
    end
    wait_drained();

    // Random: mostly nested branches, the rest single commands
    sent  = 0;
    depth = 0;
    while (sent < 1100) begin
      if ($urandom_range(0, 9) < 6) begin
        send(CMD_PUSH, pick_amount());
        repeat ($urandom_range(1, 4)) begin
          send(cmd_e'($urandom_range(CMD_FORWARD, CMD_RIGHT)), pick_amount());
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          send(CMD_POP, pick_amount());
          sent++;
        end else begin
          depth++;
        end
        sent++;
      end else begin
        send(cmd_e'($urandom_range(0, 7)), pick_amount());
        sent++;
      end
      if (depth > 20 && $urandom_range(0, 3) == 0) begin
        repeat (depth + 1) send(CMD_POP, pick_amount());
        sent  = sent + depth + 1;
        depth = 0;
      end
      if ($urandom_range(0, 199) == 0) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (reports_q.size() != 0) begin
      mismatches++;
      $display("%0t ns: %0d predicted results never arrived", $time, reports_q.size());
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tgi_pkg.sv
hw/rtl/tgi_ram.sv
hw/rtl/tgi_cordic.sv
hw/rtl/turtle_graphics_interpreter.sv
sim/tb_turtle_graphics_interpreter.sv
